### rtl/mvp_pkg.sv
// Package for the MAVLink v1 frame parser: phase codes, status codes,
// X.25 CRC byte step and the structs passed between the parser modules.
// No dependencies.
`default_nettype none

package mvp_pkg;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_LEN     = 4'd1,
		PH_SEQ     = 4'd2,
		PH_SYSID   = 4'd3,
		PH_COMPID  = 4'd4,
		PH_MSGID   = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_CRCLO   = 4'd7,
		PH_CRCHI   = 4'd8
	} phase_t;

	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_PAYLOAD = 3'd1;
	localparam logic [2:0] ST_GOOD    = 3'd2;
	localparam logic [2:0] ST_BAD_LO  = 3'd3;
	localparam logic [2:0] ST_BAD_HI  = 3'd4;

	localparam logic       KIND_LINK  = 1'b0;
	localparam logic       KIND_TABLE = 1'b1;

	localparam logic       REG_MARKER = 1'b0;
	localparam logic       REG_XEN    = 1'b1;

	localparam logic [7:0]  MARKER_RST = 8'd254;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;

	typedef struct packed {
		logic       wr;
		logic [7:0] wr_idx;
		logic [7:0] wr_data;
		logic       rd;
		logic [7:0] rd_idx;
	} tbl_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] pbyte;
		logic [7:0] pindex;
		logic [7:0] len;
		logic [7:0] seq;
		logic [7:0] sysid;
		logic [7:0] compid;
		logic [7:0] msgid;
	} res_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
		logic [7:0] t;
		t = b ^ acc[7:0];
		t = t ^ {t[3:0], 4'b0000};
		return {8'h00, acc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
	endfunction

endpackage

`default_nettype wire

### rtl/mvp_xtbl.sv
// CRC-extra table: 256-entry synchronous memory with per-entry valid bits,
// prefetch of the entry for the current message id and write forwarding.
// Depends on mvp_pkg.
`default_nettype none

module mvp_xtbl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire mvp_pkg::tbl_req_t req,
	input  wire logic [7:0]       cur_msgid,
	output logic      [7:0]       extra
);

	logic [7:0]   mem [256];
	logic [255:0] valid_q;
	logic [7:0]   rdata_s1;
	logic         rvalid_s1;
	logic         pending_q;
	logic [7:0]   extra_q;
	logic [7:0]   rd_val;

	always_ff @(posedge clk) begin
		if (accept && req.wr) begin
			mem[req.wr_idx] <= req.wr_data;
		end
		if (accept && req.rd) begin
			rdata_s1 <= mem[req.rd_idx];
		end
	end

	assign rd_val = rvalid_s1 ? rdata_s1 : 8'h00;
	assign extra  = pending_q ? rd_val : extra_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
			pending_q <= 1'b0;
			extra_q   <= 8'h00;
		end else if (accept) begin
			if (req.wr) begin
				valid_q[req.wr_idx] <= 1'b1;
			end
			if (req.rd) begin
				rvalid_s1 <= valid_q[req.rd_idx];
			end
			pending_q <= req.rd;
			if (req.wr && (req.wr_idx == cur_msgid)) begin
				extra_q <= req.wr_data;
			end else if (pending_q) begin
				extra_q <= rd_val;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/mvp_parse.sv
// Frame parser core: phase register, header capture, payload counter and
// CRC accumulator, plus the table access requests.
// Depends on mvp_pkg.
`default_nettype none

module mvp_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              kind,
	input  wire logic [7:0]        data_byte,
	input  wire logic [7:0]        table_index,
	input  wire logic [7:0]        start_marker,
	input  wire logic              crc_extra_enable,
	input  wire logic [7:0]        extra,
	output mvp_pkg::tbl_req_t      req,
	output logic      [7:0]        cur_msgid,
	output mvp_pkg::res_t          res
);

	mvp_pkg::phase_t phase_q, phase_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  seq_q, seq_d;
	logic [7:0]  sysid_q, sysid_d;
	logic [7:0]  compid_q, compid_d;
	logic [7:0]  msgid_q, msgid_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] crc_fed;
	logic [15:0] crc_fold;
	logic [7:0]  count_inc;
	logic [2:0]  status;
	logic        err;
	logic        is_marker;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mvp_pkg::PH_IDLE;
			len_q    <= 8'h00;
			seq_q    <= 8'h00;
			sysid_q  <= 8'h00;
			compid_q <= 8'h00;
			msgid_q  <= 8'h00;
			count_q  <= 8'h00;
			crc_q    <= mvp_pkg::CRC_INIT;
		end else if (accept) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			seq_q    <= seq_d;
			sysid_q  <= sysid_d;
			compid_q <= compid_d;
			msgid_q  <= msgid_d;
			count_q  <= count_d;
			crc_q    <= crc_d;
		end
	end

	assign crc_fed   = mvp_pkg::crc_feed(crc_q, data_byte);
	assign crc_fold  = crc_extra_enable ? mvp_pkg::crc_feed(crc_q, extra) : crc_q;
	assign count_inc = count_q + 8'd1;
	assign is_marker = (data_byte == start_marker);

	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		seq_d    = seq_q;
		sysid_d  = sysid_q;
		compid_d = compid_q;
		msgid_d  = msgid_q;
		count_d  = count_q;
		crc_d    = crc_q;
		status   = mvp_pkg::ST_NONE;
		err      = 1'b0;
		req.wr      = 1'b0;
		req.wr_idx  = table_index;
		req.wr_data = data_byte;
		req.rd      = 1'b0;
		req.rd_idx  = data_byte;
		if (kind == mvp_pkg::KIND_TABLE) begin
			req.wr = 1'b1;
		end else begin
			case (phase_q)
				mvp_pkg::PH_LEN: begin
					len_d   = data_byte;
					count_d = 8'h00;
					crc_d   = crc_fed;
					phase_d = mvp_pkg::PH_SEQ;
				end
				mvp_pkg::PH_SEQ: begin
					seq_d   = data_byte;
					crc_d   = crc_fed;
					phase_d = mvp_pkg::PH_SYSID;
				end
				mvp_pkg::PH_SYSID: begin
					sysid_d = data_byte;
					crc_d   = crc_fed;
					phase_d = mvp_pkg::PH_COMPID;
				end
				mvp_pkg::PH_COMPID: begin
					compid_d = data_byte;
					crc_d    = crc_fed;
					phase_d  = mvp_pkg::PH_MSGID;
				end
				mvp_pkg::PH_MSGID: begin
					msgid_d = data_byte;
					crc_d   = crc_fed;
					req.rd  = 1'b1;
					phase_d = (len_q == 8'h00) ? mvp_pkg::PH_CRCLO : mvp_pkg::PH_PAYLOAD;
				end
				mvp_pkg::PH_PAYLOAD: begin
					status  = mvp_pkg::ST_PAYLOAD;
					count_d = count_inc;
					crc_d   = crc_fed;
					if (count_inc == len_q) begin
						phase_d = mvp_pkg::PH_CRCLO;
					end
				end
				mvp_pkg::PH_CRCLO: begin
					crc_d = crc_fold;
					if (data_byte != crc_fold[7:0]) begin
						status = mvp_pkg::ST_BAD_LO;
						err    = 1'b1;
					end else begin
						phase_d = mvp_pkg::PH_CRCHI;
					end
				end
				mvp_pkg::PH_CRCHI: begin
					if (data_byte != crc_q[15:8]) begin
						status = mvp_pkg::ST_BAD_HI;
						err    = 1'b1;
					end else begin
						status  = mvp_pkg::ST_GOOD;
						phase_d = mvp_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_d = mvp_pkg::PH_IDLE;
					if (is_marker) begin
						phase_d = mvp_pkg::PH_LEN;
						crc_d   = mvp_pkg::CRC_INIT;
					end
				end
			endcase
			if (err) begin
				phase_d = mvp_pkg::PH_IDLE;
				if (is_marker) begin
					phase_d = mvp_pkg::PH_LEN;
					crc_d   = mvp_pkg::CRC_INIT;
				end
			end
		end
	end

	assign cur_msgid  = msgid_q;
	assign res.status = status;
	assign res.pbyte  = (status == mvp_pkg::ST_PAYLOAD) ? data_byte : 8'h00;
	assign res.pindex = (status == mvp_pkg::ST_PAYLOAD) ? count_q : 8'h00;
	assign res.len    = len_d;
	assign res.seq    = seq_d;
	assign res.sysid  = sysid_d;
	assign res.compid = compid_d;
	assign res.msgid  = msgid_d;

endmodule

`default_nettype wire

### rtl/mavlink_v1_frame_parser.sv
// MAVLink v1 frame parser top level: configuration registers, output
// register and the parser core with its CRC-extra table.
// Depends on mvp_pkg, mvp_parse and mvp_xtbl.
//
//  channel | direction | handshake          | content
//  s_*     | in        | s_tvalid/s_tready  | link byte or CRC-extra table write
//  m_*     | out       | m_tvalid/m_tready  | status, payload byte, header fields
//  cfg_*   | in        | cfg_valid/cfg_ready| start marker, CRC-extra enable
//
// One transfer per cycle in while s_tready is high, one result per transfer out.
// The table entry for the message id is read from memory on the message id byte
// and held in a register, so the checksum bytes may follow immediately.
// Reset clears phase, header fields, all table valid bits and loads CRC_INIT.
// s_tready drops only while a result is held and m_tready is low.
`default_nettype none

module mavlink_v1_frame_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // data_byte[7:0], table_index[15:8]
	input  wire logic        s_tuser,   // kind[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [55:0] m_tdata,   // payload_byte, payload_index, msg_len, msg_seq,
	                                    // msg_sysid, msg_compid, msg_id (bytes, low first)
	output logic      [2:0]  m_tuser,   // status[2:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic              marker_sel;
	logic [7:0]        start_marker_q;
	logic              xen_q;
	logic              accept;
	logic              out_valid_q;
	mvp_pkg::res_t     out_q;
	mvp_pkg::res_t     res;
	mvp_pkg::tbl_req_t req;
	logic [7:0]        cur_msgid;
	logic [7:0]        extra;

	assign cfg_ready  = 1'b1;
	assign marker_sel = cfg_valid && (cfg_index == mvp_pkg::REG_MARKER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= mvp_pkg::MARKER_RST;
			xen_q          <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			if (marker_sel) begin
				start_marker_q <= cfg_data;
			end else if (cfg_index == mvp_pkg::REG_XEN) begin
				xen_q <= cfg_data[0];
			end
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	mvp_parse u_parse (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.kind             (s_tuser),
		.data_byte        (s_tdata[7:0]),
		.table_index      (s_tdata[15:8]),
		.start_marker     (start_marker_q),
		.crc_extra_enable (xen_q),
		.extra            (extra),
		.req              (req),
		.cur_msgid        (cur_msgid),
		.res              (res)
	);

	mvp_xtbl u_xtbl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (req),
		.cur_msgid (cur_msgid),
		.extra     (extra)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {out_q.msgid, out_q.compid, out_q.sysid, out_q.seq,
	                   out_q.len, out_q.pindex, out_q.pbyte};

endmodule

`default_nettype wire
